### hdl/pvef_pkg.sv
// Package for the Prewitt vertical edge filter: sizes, register indexes,
// shared types and the divide-by-three helper.
// No dependencies; the top level and pvef_div use it.
package pvef_pkg;

  // Frame size limits and the widths that follow from them.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int CNT_W      = 21;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int SUM_W      = CH_W + 2;

  // Register reset values.
  localparam int RESET_WIDTH  = 320;
  localparam int RESET_HEIGHT = 240;

  // The input row counter saturates here.
  localparam logic [DIM_W-1:0] ROW_LIMIT = '1;

  // Configuration register indexes.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 1'b1;

  // Output queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // floor(d / 3) as (d * 683) >> 11, exact for every d below 2048.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_MW    = 10;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = SUM_W + DIV3_MW;

  typedef logic [PIX_W-1:0] pixel_t;

  // One word of the output queue.
  typedef struct packed {
    logic   last;
    pixel_t pix;
  } out_word_t;

  // Status of the serial divider that rebuilds the output row and column.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_stat_t;

  // A size of zero acts as one, a size above the limit acts as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Truncating division by three of a gradient magnitude.
  function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] d);
    logic [PROD_W-1:0] prod;
    prod = {{DIV3_MW{1'b0}}, d} * PROD_W'(DIV3_MUL);
    return prod[DIV3_SHIFT +: CH_W];
  endfunction

endpackage

### hdl/prewitt_vertical_edge_filter_unit.sv
// Top level of the Prewitt vertical edge filter: line stores, 3x3 window,
// gradient pipeline and output queue.
// Depends on pvef_pkg, pvef_ram and pvef_div.
//
// Usage: RGB pixels enter in raster order on the in_ stream, one word per
// pixel, with frame_start set on the first pixel of a frame. Each channel is
// filtered with the horizontal-gradient Prewitt kernel and scaled by 1/3;
// border pixels (first/last row and column) and frames under 3x3 pass
// through. The result for pixel p is produced by input word p+width+1, so
// width+1 drain words follow a frame to push its tail out; out_tlast marks
// the frame's last pixel. The out_ stream carries zero or one word per input.
// Throughput is one word per cycle while in_tready is high. After the input
// word that produces a result is accepted, it passes stage 1 (line store read
// with window sums), stage 2 (divide by three) and the queue write before
// out_tvalid rises. A four-word output queue decouples the sides: when the
// receiver stalls, in_tready drops once the queue and the two pipeline stages
// hold four words, and rises again as words drain.
// Reset sets the size to 320x240 and clears the position counters; the line
// stores are not cleared. A write of either size register rebuilds the
// output row and column with a serial divider: in_tready stays low while the
// divider runs and until its result is loaded.
module prewitt_vertical_edge_filter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic [1:0]                  in_tuser,   // bit 1 drain, bit 0 frame_start
  // Output stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // out_red, out_green, out_blue
  output logic                        out_tlast,
  // Configuration write port
  input  logic                        cfg_we,
  input  logic [pvef_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pvef_pkg::DIM_W-1:0]  cfg_wdata
);

  localparam int DW   = pvef_pkg::DIM_W;
  localparam int CW   = pvef_pkg::CNT_W;
  localparam int IW   = pvef_pkg::IDX_W;
  localparam int CHW  = pvef_pkg::CH_W;
  localparam int SW   = pvef_pkg::SUM_W;
  localparam int OCCW = pvef_pkg::FIFO_CW + 1;

  // ---------------------------------------------------------------------
  // Configuration and frame size
  // ---------------------------------------------------------------------
  logic [DW-1:0]   w_r, h_r;
  logic [CW-1:0]   total_r;
  logic [2*DW-1:0] area_full;
  logic            div_start_r;
  pvef_pkg::div_stat_t div_stat;
  logic            recalc_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= DW'(pvef_pkg::RESET_WIDTH);
      h_r         <= DW'(pvef_pkg::RESET_HEIGHT);
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_addr)
          pvef_pkg::REG_WIDTH:  w_r <= pvef_pkg::clamp_dim(cfg_wdata,
                                                           DW'(pvef_pkg::MAX_WIDTH));
          pvef_pkg::REG_HEIGHT: h_r <= pvef_pkg::clamp_dim(cfg_wdata,
                                                           DW'(pvef_pkg::MAX_HEIGHT));
          default: ;
        endcase
      end
    end
  end

  // Pixel count of a frame, registered, so it follows the size registers in the next cycle.
  assign area_full = w_r * h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CW'(pvef_pkg::RESET_WIDTH * pvef_pkg::RESET_HEIGHT);
    end else begin
      total_r <= area_full[CW-1:0];
    end
  end

  assign recalc_busy = div_start_r | div_stat.busy | div_stat.done;

  // ---------------------------------------------------------------------
  // Position counters and the per-word decision at accept time
  // ---------------------------------------------------------------------
  logic          in_acc;
  logic          frm, drn;
  logic [DW-1:0] in_col_r, in_col_nxt, col_cur;
  logic [DW-1:0] in_row_r, in_row_nxt, row_cur;
  logic [CW-1:0] ocnt_r, ocnt_nxt, ocnt_cur;
  logic [CW-1:0] orow_r, orow_nxt, orow_cur;
  logic [DW-1:0] ocol_r, ocol_nxt, ocol_cur;
  logic [DW:0]   col_p1, ocol_p1, ocol_p2;
  logic [CW:0]   orow_p2, ocnt_p1;
  logic          col_wrap, ocol_wrap;
  logic          early, emit, interior, last;
  logic [IW-1:0] rd_idx;

  assign frm    = in_tuser[0];
  assign drn    = in_tuser[1];
  assign in_acc = in_tvalid & in_tready;

  always_comb begin
    col_cur  = frm ? '0 : in_col_r;
    row_cur  = frm ? '0 : in_row_r;
    ocnt_cur = frm ? '0 : ocnt_r;
    orow_cur = frm ? '0 : orow_r;
    ocol_cur = frm ? '0 : ocol_r;
    rd_idx   = col_cur[IW-1:0];

    // Nothing is emitted until the window centers on the first pixel.
    early = (row_cur == '0 && col_cur <= w_r) ||
            (row_cur == DW'(1) && col_cur == '0);
    emit  = !early && ocnt_cur < total_r;

    orow_p2  = {1'b0, orow_cur} + (CW+1)'(2);
    ocol_p2  = {1'b0, ocol_cur} + (DW+1)'(2);
    interior = orow_cur != '0 && orow_p2 <= {{(CW-DW+1){1'b0}}, h_r} &&
               ocol_cur != '0 && ocol_p2 <= {1'b0, w_r};
    ocnt_p1  = {1'b0, ocnt_cur} + (CW+1)'(1);
    last     = ocnt_p1 == {1'b0, total_r};

    // Input position advances on every word.
    col_p1     = {1'b0, col_cur} + (DW+1)'(1);
    col_wrap   = col_p1 >= {1'b0, w_r};
    in_col_nxt = col_wrap ? '0 : col_p1[DW-1:0];
    in_row_nxt = (col_wrap && row_cur < pvef_pkg::ROW_LIMIT) ?
                 row_cur + DW'(1) : row_cur;

    // Output position advances on emitted words only.
    ocol_p1   = {1'b0, ocol_cur} + (DW+1)'(1);
    ocol_wrap = ocol_p1 >= {1'b0, w_r};
    ocnt_nxt  = ocnt_cur;
    orow_nxt  = orow_cur;
    ocol_nxt  = ocol_cur;
    if (emit) begin
      ocnt_nxt = ocnt_p1[CW-1:0];
      ocol_nxt = ocol_wrap ? '0 : ocol_p1[DW-1:0];
      orow_nxt = ocol_wrap ? orow_cur + CW'(1) : orow_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      ocnt_r   <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
    end else if (in_acc) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      ocnt_r   <= ocnt_nxt;
      orow_r   <= orow_nxt;
      ocol_r   <= ocol_nxt;
    end else if (div_stat.done) begin
      orow_r   <= div_stat.quot;
      ocol_r   <= div_stat.rem;
    end
  end

  pvef_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (ocnt_r),
    .divisor  (w_r),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------------
  // Stage 1: line store read data, forwarding, write-back, window shift
  // ---------------------------------------------------------------------
  logic             s1_valid_r, s1_emit_r, s1_int_r, s1_last_r;
  logic [IW-1:0]    s1_idx_r;
  pvef_pkg::pixel_t s1_pix_r;
  logic             hit_r;
  pvef_pkg::pixel_t fwd_top_r, fwd_mid_r;
  pvef_pkg::pixel_t up_rdata, mid_rdata, top_cur, mid_cur;
  pvef_pkg::pixel_t win_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
    if (in_acc) begin
      s1_emit_r <= emit;
      s1_int_r  <= interior;
      s1_last_r <= last;
      s1_idx_r  <= rd_idx;
      s1_pix_r  <= drn ? '0 : in_tdata;
      // The word in stage 1 writes this entry at the same edge as the read.
      hit_r     <= s1_valid_r && (s1_idx_r == rd_idx);
      fwd_top_r <= mid_cur;
      fwd_mid_r <= s1_pix_r;
    end
  end

  assign top_cur = hit_r ? fwd_top_r : up_rdata;
  assign mid_cur = hit_r ? fwd_mid_r : mid_rdata;

  pvef_ram #(
    .WIDTH (pvef_pkg::PIX_W),
    .DEPTH (pvef_pkg::MAX_WIDTH)
  ) u_upper_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_idx_r),
    .wdata (mid_cur),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (up_rdata)
  );

  pvef_ram #(
    .WIDTH (pvef_pkg::PIX_W),
    .DEPTH (pvef_pkg::MAX_WIDTH)
  ) u_middle_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_idx_r),
    .wdata (s1_pix_r),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (mid_rdata)
  );

  // Window shifts left by one column; the new right column enters.
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]     <= win_r[k*3+1];
        win_r[k*3+1]   <= win_r[k*3+2];
      end
      win_r[2] <= top_cur;
      win_r[5] <= mid_cur;
      win_r[8] <= s1_pix_r;
    end
  end

  // Column sums of the shifted window: right is the new column, left is
  // the current middle column.
  logic [SW-1:0] plus_c [pvef_pkg::NUM_CH];
  logic [SW-1:0] minus_c [pvef_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < pvef_pkg::NUM_CH; c++) begin
      plus_c[c]  = {2'b0, top_cur[c*CHW +: CHW]} + {2'b0, mid_cur[c*CHW +: CHW]} +
                   {2'b0, s1_pix_r[c*CHW +: CHW]};
      minus_c[c] = {2'b0, win_r[1][c*CHW +: CHW]} + {2'b0, win_r[4][c*CHW +: CHW]} +
                   {2'b0, win_r[7][c*CHW +: CHW]};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: magnitude, divide by three, border selection
  // ---------------------------------------------------------------------
  logic             s2_valid_r, s2_int_r, s2_last_r;
  logic [SW-1:0]    s2_plus_r [pvef_pkg::NUM_CH];
  logic [SW-1:0]    s2_minus_r [pvef_pkg::NUM_CH];
  pvef_pkg::pixel_t s2_ctr_r;
  pvef_pkg::pixel_t grad_pix;
  logic [SW-1:0]    diff_c [pvef_pkg::NUM_CH];
  pvef_pkg::out_word_t res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
    if (s1_valid_r && s1_emit_r) begin
      s2_int_r   <= s1_int_r;
      s2_last_r  <= s1_last_r;
      s2_plus_r  <= plus_c;
      s2_minus_r <= minus_c;
      s2_ctr_r   <= win_r[5];
    end
  end

  always_comb begin
    for (int c = 0; c < pvef_pkg::NUM_CH; c++) begin
      diff_c[c] = (s2_plus_r[c] >= s2_minus_r[c]) ? s2_plus_r[c] - s2_minus_r[c] :
                                                    s2_minus_r[c] - s2_plus_r[c];
      grad_pix[c*CHW +: CHW] = pvef_pkg::div3(diff_c[c]);
    end
    res_word.last = s2_last_r;
    res_word.pix  = s2_int_r ? grad_pix : s2_ctr_r;
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  pvef_pkg::out_word_t              fifo_r [pvef_pkg::FIFO_DEPTH];
  logic [pvef_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pvef_pkg::FIFO_CW-1:0]     cnt_r;
  logic                             fifo_wr, fifo_rd;
  logic [OCCW-1:0]                  occ;
  pvef_pkg::out_word_t              head;

  assign fifo_wr = s2_valid_r;
  assign fifo_rd = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= wr_ptr_r + pvef_pkg::FIFO_AW'(1);
      end
      if (fifo_rd) begin
        rd_ptr_r <= rd_ptr_r + pvef_pkg::FIFO_AW'(1);
      end
      if (fifo_wr && !fifo_rd) begin
        cnt_r <= cnt_r + pvef_pkg::FIFO_CW'(1);
      end else if (!fifo_wr && fifo_rd) begin
        cnt_r <= cnt_r - pvef_pkg::FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_r[wr_ptr_r] <= res_word;
    end
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = head.pix;
  assign out_tlast  = head.last;

  // Room must remain for every word already inside the pipeline.
  assign occ       = {1'b0, cnt_r} + OCCW'(s1_valid_r) + OCCW'(s2_valid_r);
  assign in_tready = !recalc_busy && (occ < OCCW'(pvef_pkg::FIFO_DEPTH));

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr && !fifo_rd |-> cnt_r < pvef_pkg::FIFO_CW'(pvef_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_ocol_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !recalc_busy |-> ocol_r < w_r)
    else $error("output column outside the frame width");

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(in_tvalid && in_tready))
    else $error("stage 1 word without an accepted input word");

  a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r |=> s2_valid_r)
    else $error("emitted word lost between stage 1 and stage 2");

endmodule

### hdl/pvef_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same entry in one cycle return the old data.
// No dependencies.
module pvef_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/pvef_div.sv
// Serial restoring divider, one quotient bit per cycle, used to rebuild the
// output row and column from the output count after a size register write.
// Depends on pvef_pkg.
module pvef_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pvef_pkg::CNT_W-1:0] dividend,
  input  logic [pvef_pkg::DIM_W-1:0] divisor,
  output pvef_pkg::div_stat_t       stat
);

  localparam int STEP_W = $clog2(pvef_pkg::CNT_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [pvef_pkg::CNT_W-1:0] quo_r, quo_nxt;
  logic [pvef_pkg::DIM_W-1:0] rem_r, rem_nxt;
  logic [pvef_pkg::DIM_W-1:0] dsr_r, dsr_nxt;
  logic [pvef_pkg::DIM_W:0]   rem_sh;
  logic [pvef_pkg::DIM_W:0]   rem_sub;
  logic                       fits;

  // One shift-and-subtract step; the dividend shifts out as quotient bits shift in.
  always_comb begin
    rem_sh   = {rem_r, quo_r[pvef_pkg::CNT_W-1]};
    rem_sub  = rem_sh - {1'b0, dsr_r};
    fits     = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[pvef_pkg::CNT_W-2:0], fits};
      rem_nxt  = fits ? rem_sub[pvef_pkg::DIM_W-1:0] : rem_sh[pvef_pkg::DIM_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(pvef_pkg::CNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = quo_r;
  assign stat.rem  = rem_r;

endmodule
